// ----- rtl/bsmf_pkg.sv -----
// ----------------------------------------------------------------------------
// bsmf_pkg
// Shared types and constants of the border shrink median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bsmf_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_WINDOW = 7;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam int J_ROW_W  = 13;
  localparam int J_COL_W  = 13;
  localparam int J_RING_W = 4;
  localparam int RAD_W    = 3;

  typedef struct packed {
    logic       op;
    logic [7:0] pixel_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] median_out;
    logic       frame_end;
  } out_beat_t;

  typedef struct packed {
    logic [J_ROW_W-1:0]  row;
    logic [J_COL_W-1:0]  col;
    logic [J_RING_W-1:0] ring;
    logic                last;
  } job_t;

  typedef struct packed {
    logic               busy;
    logic [J_ROW_W-1:0] row;
  } back_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_TAIL,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/bsmf_ram.sv -----
// ----------------------------------------------------------------------------
// bsmf_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bsmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/bsmf_queue.sv -----
// ----------------------------------------------------------------------------
// bsmf_queue
// Two entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bsmf_queue import bsmf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      full,
  output logic      empty
);

  job_t       slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign head  = slot[rp];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bsmf_front.sv -----
// ----------------------------------------------------------------------------
// bsmf_front
// Accepts beats, stores pixels, tracks positions and issues median jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module bsmf_front import bsmf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  localparam int CW   = $clog2(MAX_WIDTH + 1),
  localparam int RW   = $clog2(MAX_HEIGHT + 1),
  localparam int CAW  = $clog2(MAX_WIDTH),
  localparam int RING = 2 * (MAX_WINDOW / 2) + 2,
  localparam int RB   = $clog2(RING),
  localparam int AW   = RB + CAW
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_beat_t              in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       q_push,
  output job_t                       q_job,
  input  wire logic                  q_full,
  input  wire logic                  q_empty,
  input  wire logic [J_ROW_W-1:0]    q_head_row,
  input  wire back_stat_t            back_stat,
  output logic [CW-1:0]              w,
  output logic [RW-1:0]              h,
  output logic [RAD_W-1:0]           r,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [7:0]                 mem_wdata
);

  logic [CFG_DATA_W-1:0] reg_width;
  logic [CFG_DATA_W-1:0] reg_height;
  logic [2:0]            reg_window;

  logic [RW-1:0] in_row, in_row_next;
  logic [CW-1:0] in_col, in_col_next;
  logic [RB-1:0] in_ring, in_ring_next;
  logic [RW-1:0] out_row;
  logic [CW-1:0] out_col;
  logic [RB-1:0] out_ring;

  logic          wr;
  logic [RW:0]   need_row;
  logic [CW:0]   need_col;
  logic          rdy;
  logic          last;
  logic          acc;
  logic [J_ROW_W-1:0] oldest;
  logic          hazard_ok;
  logic          start_ok;

  always_comb begin
    if (reg_width == '0) w = CW'(1);
    else if (32'(reg_width) > 32'(MAX_WIDTH)) w = CW'(MAX_WIDTH);
    else w = CW'(reg_width);
    if (reg_height == '0) h = RW'(1);
    else if (32'(reg_height) > 32'(MAX_HEIGHT)) h = RW'(MAX_HEIGHT);
    else h = RW'(reg_height);
    if (32'(reg_window) > 32'(MAX_WINDOW)) r = RAD_W'(MAX_WINDOW / 2);
    else r = RAD_W'(reg_window >> 1);
  end

  always_comb begin
    wr           = (in_data.op == OP_PIXEL) && (in_row < h);
    in_row_next  = in_row;
    in_col_next  = in_col;
    in_ring_next = in_ring;
    if (wr) begin
      if (in_col + CW'(1) >= w) begin
        in_col_next  = '0;
        in_row_next  = in_row + RW'(1);
        in_ring_next = (32'(in_ring) == RING - 1) ? '0 : in_ring + RB'(1);
      end else begin
        in_col_next = in_col + CW'(1);
      end
    end

    need_row = {1'b0, out_row} + (RW+1)'(r);
    if (need_row > {1'b0, h - RW'(1)}) need_row = {1'b0, h - RW'(1)};
    need_col = {1'b0, out_col} + (CW+1)'(r);
    if (need_col > {1'b0, w - CW'(1)}) need_col = {1'b0, w - CW'(1)};

    rdy  = (out_row < h) &&
           (({1'b0, in_row_next} > need_row) ||
            (({1'b0, in_row_next} == need_row) && ({1'b0, in_col_next} > need_col)));
    last = (out_row == h - RW'(1)) && (out_col >= w - CW'(1));

    if (back_stat.busy) oldest = back_stat.row;
    else if (!q_empty) oldest = q_head_row;
    else oldest = J_ROW_W'(out_row);

    hazard_ok = ((J_ROW_W+1)'(in_row) + (J_ROW_W+1)'(r)) <
                ({1'b0, oldest} + (J_ROW_W+1)'(RING));
    start_ok  = !((in_row == '0) && (in_col == '0)) || (q_empty && !back_stat.busy);
    in_ready  = !q_full && hazard_ok && start_ok;
    acc       = in_valid && in_ready;

    q_push     = acc && rdy;
    q_job.row  = J_ROW_W'(out_row);
    q_job.col  = J_COL_W'(out_col);
    q_job.ring = J_RING_W'(out_ring);
    q_job.last = last;

    mem_we    = acc && wr;
    mem_waddr = {in_ring, in_col[CAW-1:0]};
    mem_wdata = in_data.pixel_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_width  <= CFG_DATA_W'(64);
      reg_height <= CFG_DATA_W'(64);
      reg_window <= 3'd3;
      in_row     <= '0;
      in_col     <= '0;
      in_ring    <= '0;
      out_row    <= '0;
      out_col    <= '0;
      out_ring   <= '0;
    end else if (cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT ||
                            cfg_index == REG_WINDOW_SIZE)) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  reg_width  <= cfg_data;
        REG_IMAGE_HEIGHT: reg_height <= cfg_data;
        default:          reg_window <= cfg_data[2:0];
      endcase
      in_row   <= '0;
      in_col   <= '0;
      in_ring  <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_ring <= '0;
    end else if (acc) begin
      if (rdy && last) begin
        in_row   <= '0;
        in_col   <= '0;
        in_ring  <= '0;
        out_row  <= '0;
        out_col  <= '0;
        out_ring <= '0;
      end else begin
        in_row  <= in_row_next;
        in_col  <= in_col_next;
        in_ring <= in_ring_next;
        if (rdy) begin
          if (out_col + CW'(1) >= w) begin
            out_col  <= '0;
            out_row  <= out_row + RW'(1);
            out_ring <= (32'(out_ring) == RING - 1) ? '0 : out_ring + RB'(1);
          end else begin
            out_col <= out_col + CW'(1);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bsmf_back.sv -----
// ----------------------------------------------------------------------------
// bsmf_back
// Gathers one window from the line store, insertion sorts it, gives the median.
// ----------------------------------------------------------------------------
`default_nettype none

module bsmf_back import bsmf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  localparam int CW   = $clog2(MAX_WIDTH + 1),
  localparam int RW   = $clog2(MAX_HEIGHT + 1),
  localparam int CAW  = $clog2(MAX_WIDTH),
  localparam int RING = 2 * (MAX_WINDOW / 2) + 2,
  localparam int RB   = $clog2(RING),
  localparam int AW   = RB + CAW
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CW-1:0]    w,
  input  wire logic [RW-1:0]    h,
  input  wire logic [RAD_W-1:0] r,
  input  wire logic             q_empty,
  output logic                  q_pop,
  input  wire job_t             q_job,
  output logic [AW-1:0]         mem_raddr,
  input  wire logic [7:0]       mem_rdata,
  output back_stat_t            stat,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_beat_t             out_data
);

  localparam int SIDE = 2 * (MAX_WINDOW / 2) + 1;
  localparam int NW   = SIDE * SIDE;
  localparam int NB   = $clog2(NW + 1);
  localparam int IB   = (NW > 1) ? $clog2(NW) : 1;

  back_state_t state, state_next;

  logic          job_last;
  logic [RW-1:0] job_row;
  logic [RW-1:0] y, yend;
  logic [CW-1:0] x, xstart, xend;
  logic [RB-1:0] ry;
  logic          rd_v;
  logic [NB-1:0] cnt;
  logic [7:0]    win [NW];
  logic [7:0]    win_next [NW];
  logic          lt [NW];

  logic [RW-1:0] jr, ys, ye;
  logic [CW-1:0] jc, xs, xe;
  logic [RW:0]   ysum;
  logic [CW:0]   xsum;
  logic [RB:0]   rs;
  logic [RAD_W-1:0] d;
  logic          load_out;
  logic [IB-1:0] mid;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!q_empty) state_next = BK_RUN;
      BK_RUN:  if (x == xend && y == yend) state_next = BK_TAIL;
      BK_TAIL: state_next = BK_DONE;
      BK_DONE: if (!out_valid || out_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == BK_IDLE) && !q_empty;
    load_out  = (state == BK_DONE) && (!out_valid || out_ready);
    mem_raddr = {ry, x[CAW-1:0]};
    stat.busy = (state != BK_IDLE);
    stat.row  = J_ROW_W'(job_row);
    mid       = IB'(cnt >> 1);

    jr   = RW'(q_job.row);
    jc   = CW'(q_job.col);
    ys   = (jr >= RW'(r)) ? jr - RW'(r) : '0;
    ysum = {1'b0, jr} + (RW+1)'(r);
    ye   = (ysum > {1'b0, h - RW'(1)}) ? h - RW'(1) : ysum[RW-1:0];
    xs   = (jc >= CW'(r)) ? jc - CW'(r) : '0;
    xsum = {1'b0, jc} + (CW+1)'(r);
    xe   = (xsum > {1'b0, w - CW'(1)}) ? w - CW'(1) : xsum[CW-1:0];
    d    = RAD_W'(jr - ys);
    if ((RB+1)'(q_job.ring) >= (RB+1)'(d)) rs = (RB+1)'(q_job.ring) - (RB+1)'(d);
    else rs = (RB+1)'(q_job.ring) + (RB+1)'(RING) - (RB+1)'(d);

    for (int i = 0; i < NW; i++) begin
      lt[i] = (NB'(i) < cnt) && (win[i] <= mem_rdata);
    end
    win_next[0] = lt[0] ? win[0] : mem_rdata;
    for (int i = 1; i < NW; i++) begin
      if (lt[i]) win_next[i] = win[i];
      else if (lt[i-1]) win_next[i] = mem_rdata;
      else win_next[i] = win[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= (state == BK_RUN);
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_row  <= jr;
      job_last <= q_job.last;
      y        <= ys;
      yend     <= ye;
      x        <= xs;
      xstart   <= xs;
      xend     <= xe;
      ry       <= rs[RB-1:0];
      cnt      <= '0;
    end else begin
      if (state == BK_RUN) begin
        if (x == xend) begin
          x <= xstart;
          if (y != yend) begin
            y  <= y + RW'(1);
            ry <= (32'(ry) == RING - 1) ? '0 : ry + RB'(1);
          end
        end else begin
          x <= x + CW'(1);
        end
      end
      if (rd_v) begin
        win <= win_next;
        cnt <= cnt + NB'(1);
      end
    end
    if (load_out) begin
      out_data.median_out <= win[mid];
      out_data.frame_end  <= job_last;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) 32'(cnt) <= NW)
    else $error("window count overflow");
  a_done_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == BK_DONE |-> cnt != '0)
    else $error("median of empty window");
  a_run_range: assert property (@(posedge clk) disable iff (rst)
    state == BK_RUN |-> (x <= xend && y <= yend))
    else $error("window scan out of range");

endmodule

`default_nettype wire

// ----- rtl/border_shrink_median_filter.sv -----
// ----------------------------------------------------------------------------
// border_shrink_median_filter
// Streaming 2-D median filter with windows that shrink at the image border.
// ----------------------------------------------------------------------------
//  channel  direction  beat fields              handshake
//  in       input      op, pixel_in             in_valid / in_ready
//  out      output     median_out, frame_end    out_valid / out_ready
//  cfg      input      cfg_index, cfg_data      cfg_we
//
//  input beats are taken one per cycle while the job queue has room and neither stall below holds
//  the back end serves one job at a time, reading its n window pixels (n up to
//  49) one by one through the single read port of the line store
//  input stalls when a new pixel would overwrite a row an open job still needs,
//  and at frame start until the previous frame's jobs are done
//  synchronous reset, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module border_shrink_median_filter import bsmf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_beat_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_beat_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int CAW   = $clog2(MAX_WIDTH);
  localparam int RING  = 2 * (MAX_WINDOW / 2) + 2;
  localparam int RB    = $clog2(RING);
  localparam int AW    = RB + CAW;
  localparam int DEPTH = RING * (2 ** CAW);

  logic             q_push, q_pop, q_full, q_empty;
  job_t             q_job, q_head;
  back_stat_t       back_stat;
  logic [CW-1:0]    w;
  logic [RW-1:0]    h;
  logic [RAD_W-1:0] r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, mem_rdata;

  bsmf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_WINDOW(MAX_WINDOW))
  u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data, .cfg_we, .cfg_index, .cfg_data,
    .q_push, .q_job, .q_full, .q_empty, .q_head_row(q_head.row), .back_stat,
    .w, .h, .r, .mem_we, .mem_waddr, .mem_wdata
  );

  bsmf_queue u_queue (
    .clk, .rst, .push(q_push), .push_job(q_job), .pop(q_pop), .head(q_head),
    .full(q_full), .empty(q_empty)
  );

  bsmf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  bsmf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_WINDOW(MAX_WINDOW))
  u_back (
    .clk, .rst, .w, .h, .r, .q_empty, .q_pop, .q_job(q_head),
    .mem_raddr, .mem_rdata, .stat(back_stat), .out_valid, .out_ready, .out_data
  );

endmodule

`default_nettype wire
